### rtl/core/des_pkg.sv
package des_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned POS_W            = 16;
  localparam int unsigned SEEK_W           = 21;
  localparam int unsigned STORE_DEPTH_MAX  = 32;
  localparam int unsigned DEF_MAX_REQUESTS = 32;
  localparam int unsigned DEF_CYL_BITS     = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_EMPTY
  } st_e;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] position;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  served_cylinder;
    logic [SEEK_W-1:0] seek_total;
    logic              last;
    logic              empty_batch;
    logic              dropped;
  } out_res_t;

endpackage

### rtl/core/des_store.sv
module des_store import des_pkg::*; #(
  parameter int unsigned DEPTH = STORE_DEPTH_MAX,
  parameter int unsigned WIDTH = DEF_CYL_BITS,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  // Single write port, single registered read port. Writes happen only
  // while idle and reads only while scanning, so no forwarding is needed.
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/des_ctrl.sv
module des_ctrl import des_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int unsigned CYL_BITS     = DEF_CYL_BITS,
  localparam int unsigned CAP   = (MAX_REQUESTS < STORE_DEPTH_MAX) ? MAX_REQUESTS
                                                                   : STORE_DEPTH_MAX,
  localparam int unsigned CW    = (CYL_BITS < POS_W) ? CYL_BITS : POS_W,
  localparam int unsigned IDX_W = (CAP > 1) ? $clog2(CAP) : 1,
  localparam int unsigned CNT_W = $clog2(CAP + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_res_t         out_res_o,
  // request store port
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output logic [CW-1:0]    mem_wdata_o,
  output logic             mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  logic [CW-1:0]    mem_rdata_i
);

  // control state
  st_e              state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             drop_q, drop_d;
  logic             phase_up_q, phase_up_d;
  logic [CAP-1:0]   served_q, served_d;
  logic [IDX_W-1:0] scan_addr_q, scan_addr_d;
  logic             issue_q, issue_d;
  logic             rd_vld_q, rd_vld_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  logic [SEEK_W-1:0] seek_q, seek_d;

  // payload
  logic [CW-1:0]    head0_q, head0_d;
  logic [CW-1:0]    head_q, head_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0]    best_val_q, best_val_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  out_res_t         out_res_q, out_res_d;

  logic             in_acc;
  logic             slot_free;
  logic [CW-1:0]    pos_c;
  logic             elig;
  logic             better;
  logic [CW-1:0]    move_len;
  logic [SEEK_W:0]  seek_sum;
  logic [SEEK_W-1:0] seek_sat;
  logic             is_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pos_c      = in_req_i.position[CW-1:0];

  assign mem_we_o    = in_acc && (in_req_i.cmd == CMD_LOAD) && (count_q < CNT_W'(CAP));
  assign mem_waddr_o = count_q[IDX_W-1:0];
  assign mem_wdata_o = pos_c;
  assign mem_re_o    = (state_q == ST_SCAN) && issue_q;
  assign mem_raddr_o = scan_addr_q;

  // candidate test on the entry read last cycle
  assign elig   = !served_q[rd_idx_q] &&
                  (phase_up_q ? (mem_rdata_i > head0_q) : (mem_rdata_i <= head0_q));
  assign better = !found_q ||
                  (phase_up_q ? (mem_rdata_i < best_val_q) : (mem_rdata_i > best_val_q));

  assign move_len = (head_q > best_val_q) ? (head_q - best_val_q) : (best_val_q - head_q);
  assign seek_sum = {1'b0, seek_q} + (SEEK_W + 1)'(move_len);
  assign seek_sat = seek_sum[SEEK_W] ? {SEEK_W{1'b1}} : seek_sum[SEEK_W-1:0];
  assign is_last  = (k_q == n_q - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    k_d         = k_q;
    drop_d      = drop_q;
    phase_up_d  = phase_up_q;
    served_d    = served_q;
    scan_addr_d = scan_addr_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    seek_d      = seek_q;
    head0_d     = head0_q;
    head_d      = head_q;
    rd_idx_d    = rd_idx_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.cmd == CMD_LOAD) begin
            if (count_q < CNT_W'(CAP)) begin
              count_d = count_q + CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            n_d         = count_q;
            drop_d      = ovf_q;
            count_d     = '0;
            ovf_d       = 1'b0;
            head0_d     = pos_c;
            head_d      = pos_c;
            seek_d      = '0;
            k_d         = '0;
            phase_up_d  = 1'b0;
            served_d    = '0;
            scan_addr_d = '0;
            issue_d     = 1'b1;
            found_d     = 1'b0;
            state_d     = (count_q == '0) ? ST_EMPTY : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issue_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_addr_q;
          if (CNT_W'(scan_addr_q) == n_q - CNT_W'(1)) begin
            issue_d = 1'b0;
          end else begin
            scan_addr_d = scan_addr_q + IDX_W'(1);
          end
        end
        if (rd_vld_q) begin
          if (elig && better) begin
            found_d    = 1'b1;
            best_val_d = mem_rdata_i;
            best_idx_d = rd_idx_q;
          end
          if (CNT_W'(rd_idx_q) == n_q - CNT_W'(1)) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (found_q) begin
          state_d = ST_EMIT;
        end else if (!phase_up_q) begin
          // lower group exhausted, sweep upward
          phase_up_d  = 1'b1;
          scan_addr_d = '0;
          issue_d     = 1'b1;
          state_d     = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d               = 1'b1;
          out_res_d.served_cylinder = POS_W'(best_val_q);
          out_res_d.seek_total      = seek_sat;
          out_res_d.last            = is_last;
          out_res_d.empty_batch     = 1'b0;
          out_res_d.dropped         = drop_q;
          seek_d                    = seek_sat;
          head_d                    = best_val_q;
          served_d[best_idx_q]      = 1'b1;
          k_d                       = k_q + CNT_W'(1);
          found_d                   = 1'b0;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            scan_addr_d = '0;
            issue_d     = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_res_d   = '0;
          out_res_d.empty_batch = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      drop_q      <= 1'b0;
      phase_up_q  <= 1'b0;
      served_q    <= '0;
      scan_addr_q <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      seek_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      k_q         <= k_d;
      drop_q      <= drop_d;
      phase_up_q  <= phase_up_d;
      served_q    <= served_d;
      scan_addr_q <= scan_addr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      seek_q      <= seek_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head0_q    <= head0_d;
    head_q     <= head_d;
    rd_idx_q   <= rd_idx_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    out_res_q  <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

### rtl/core/disk_elevator_scheduler_top.sv
// Elevator (SCAN) disk request scheduler.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): a request with cmd
// load stores one cylinder; a full store drops it and flags the batch.
// A request with cmd start carries the head cylinder and serves the batch:
// cylinders at or below the head in descending order, then those above it
// in ascending order. The store is emptied after every start.
// Output channel (out_valid_o / out_ready_i / out_res_o): one result per
// served cylinder with the running seek total; the final one has last set.
// An empty batch gives one result with empty_batch set and all else zero.
//
// Each result of a batch takes one scan pass over the single read port of
// the store, plus one extra pass when the sweep turns upward. Input is held
// off while a batch is served; after the last result is registered the block
// takes requests again while that result waits in the output register.
// A stalled receiver holds the scan at its next result.
// Reset clears the request count and the overflow flag; no store sweep.
module disk_elevator_scheduler_top import des_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int unsigned CYL_BITS     = DEF_CYL_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o
);

  // store depth never exceeds 32 entries; cylinders use the low bits only
  localparam int unsigned CAP   = (MAX_REQUESTS < STORE_DEPTH_MAX) ? MAX_REQUESTS
                                                                   : STORE_DEPTH_MAX;
  localparam int unsigned CW    = (CYL_BITS < POS_W) ? CYL_BITS : POS_W;
  localparam int unsigned IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [CW-1:0]    mem_rdata;

  des_ctrl #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYL_BITS     (CYL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // pending cylinders, packed from entry zero
  des_store #(
    .DEPTH (CAP),
    .WIDTH (CW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/core/des_checker.sv
module des_checker import des_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_res_t out_res_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // empty batch result carries nothing else
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.empty_batch |->
      out_res_o.served_cylinder == '0 && out_res_o.seek_total == '0 &&
      !out_res_o.last && !out_res_o.dropped)
    else $error("empty batch result has nonzero fields");

  // serving locks out new requests
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.cmd == CMD_START |=> !in_ready_o)
    else $error("request taken right after start");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.cmd == CMD_LOAD && !out_valid_o
      |=> !out_valid_o)
    else $error("result after load");

endmodule

bind disk_elevator_scheduler_top des_checker u_des_checker (.*);
